>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Each macro expects clk_i and rst_ni in scope of the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define CAU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// The expression must never hold at a clock edge.
`define CAU_ASSERT_NEVER(name, expr, msg) \
  `CAU_ASSERT(name, !(expr), msg)

`endif

>>> hw/rtl/cau_pkg.sv
// Package for the complex arithmetic unit: command and status codes, pipeline
// constants and the structs that travel down the divide and square-root pipe.
// No dependencies.
package cau_pkg;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_MAG = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_SAT      = 2'd2
  } status_e;

  // One quotient or root bit per iteration stage.
  localparam int unsigned NSTEP = 33;
  // Input register, multiply, sum, absolute value, setup, iterations, round, saturate.
  localparam int unsigned LATENCY = 5 + NSTEP + 2;

  // Partial remainder, quotient or root, and the dividend or radicand bits still
  // to be shifted in (most significant first).
  typedef struct packed {
    logic [64:0] rem;
    logic [32:0] quo;
    logic [65:0] feed;
  } lane_t;

  // Everything an item carries besides the iteration lanes.
  typedef struct packed {
    logic        neg_re;
    logic        neg_im;
    logic        ovf_re;
    logic        ovf_im;
    logic        div_zero;
    logic [31:0] res_re;
    logic [31:0] res_im;
    status_e     st;
  } side_t;

  typedef struct packed {
    logic [2:0]  cmd;
    side_t       side;
    logic [63:0] den;
    lane_t       re;
    lane_t       im;
  } iter_t;

endpackage

>>> hw/rtl/cau_iter_stage.sv
// One registered stage of the shared divide / square-root pipeline.
// Each stage produces one quotient bit (division) or one root bit (magnitude).
// Depends on cau_pkg.
module cau_iter_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  cau_pkg::iter_t data_i,
  output logic           valid_o,
  output cau_pkg::iter_t data_o
);

  logic           valid_q;
  cau_pkg::iter_t data_d;
  cau_pkg::iter_t data_q;
  logic           sqrt_mode;

  // Restoring step: one dividend bit against the divisor, or two radicand bits
  // against the trial value 4*root+1.
  function automatic cau_pkg::lane_t step(cau_pkg::lane_t l, logic [63:0] den, logic sq);
    logic [64:0]    r2;
    logic [64:0]    t;
    logic           take;
    cau_pkg::lane_t o;
    if (sq) begin
      r2     = {l.rem[62:0], l.feed[65:64]};
      t      = {30'd0, l.quo, 2'b01};
      o.feed = {l.feed[63:0], 2'b00};
    end else begin
      r2     = {l.rem[63:0], l.feed[65]};
      t      = {1'b0, den};
      o.feed = {l.feed[64:0], 1'b0};
    end
    take  = (r2 >= t);
    o.rem = take ? (r2 - t) : r2;
    o.quo = {l.quo[31:0], take};
    return o;
  endfunction

  always_comb begin
    sqrt_mode = (data_i.cmd == cau_pkg::CMD_MAG);
    data_d    = data_i;
    data_d.re = step(data_i.re, data_i.den, sqrt_mode);
    data_d.im = step(data_i.im, data_i.den, sqrt_mode);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hw/rtl/complex_arith_unit.sv
// Complex arithmetic unit on signed fixed point with FRAC_BITS fractional bits.
// Depends on cau_pkg and cau_iter_stage.
//
// A command is taken at every rising edge where start_i is high and busy_o is
// low; busy_o stays low, so one command can be issued in every cycle. Each
// command gives exactly one result, shown on res_re_o, res_im_o and status_o
// for one cycle with done_o high, in issue order. All commands go through
// the same stages: five setup stages (input register, four 32x32 products and
// two squares, sums, absolute value, divider setup), 33 iteration stages that
// each produce one quotient or root bit, and two stages for rounding and
// saturation. The receiver cannot stall the pipeline.
module complex_arith_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  command_i,
  input  logic [31:0] a_re_i,
  input  logic [31:0] a_im_i,
  input  logic [31:0] b_re_i,
  input  logic [31:0] b_im_i,
  output logic [31:0] res_re_o,
  output logic [31:0] res_im_o,
  output logic [1:0]  status_o,
  output logic        done_o
);

  localparam int unsigned K = 32 - FRAC_BITS;
  localparam logic [63:0] HALF    = 64'd1 << (FRAC_BITS - 1);
  localparam logic [63:0] POS_LIM = (64'd1 << (31 + FRAC_BITS)) - HALF;
  localparam logic [63:0] NEG_LIM = (64'h8000_0001 << FRAC_BITS) - HALF;
  localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] MAX_NEG = 32'h8000_0000;

  // Stage 1: input registers.
  logic               v1_q;
  logic [2:0]         cmd1_q;
  logic signed [31:0] ar1_q, ai1_q, br1_q, bi1_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cmd1_q <= command_i;
      ar1_q  <= a_re_i;
      ai1_q  <= a_im_i;
      br1_q  <= b_re_i;
      bi1_q  <= b_im_i;
    end
  end

  // Stage 2: products, and add or subtract finished outright.
  logic               v2_q;
  logic [2:0]         cmd2_q;
  logic signed [63:0] prr2_q, pii2_q, pri2_q, pir2_q, sq02_q, sq12_q;
  logic signed [63:0] prr2_d, pii2_d, pri2_d, pir2_d, sq02_d, sq12_d;
  logic signed [31:0] x0, x1;
  logic signed [32:0] s_re, s_im;
  logic [31:0]        as2_re_d, as2_im_d, as2_re_q, as2_im_q;
  cau_pkg::status_e   as2_st_d, as2_st_q;
  logic               sat_re2, sat_im2;

  always_comb begin
    x0     = (cmd1_q == cau_pkg::CMD_MAG) ? ar1_q : br1_q;
    x1     = (cmd1_q == cau_pkg::CMD_MAG) ? ai1_q : bi1_q;
    prr2_d = ar1_q * br1_q;
    pii2_d = ai1_q * bi1_q;
    pri2_d = ar1_q * bi1_q;
    pir2_d = ai1_q * br1_q;
    sq02_d = x0 * x0;
    sq12_d = x1 * x1;
    if (cmd1_q == cau_pkg::CMD_SUB) begin
      s_re = 33'(ar1_q) - 33'(br1_q);
      s_im = 33'(ai1_q) - 33'(bi1_q);
    end else begin
      s_re = 33'(ar1_q) + 33'(br1_q);
      s_im = 33'(ai1_q) + 33'(bi1_q);
    end
    sat_re2  = s_re[32] ^ s_re[31];
    sat_im2  = s_im[32] ^ s_im[31];
    as2_re_d = sat_re2 ? (s_re[32] ? MAX_NEG : MAX_POS) : s_re[31:0];
    as2_im_d = sat_im2 ? (s_im[32] ? MAX_NEG : MAX_POS) : s_im[31:0];
    as2_st_d = (sat_re2 || sat_im2) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      cmd2_q   <= cmd1_q;
      prr2_q   <= prr2_d;
      pii2_q   <= pii2_d;
      pri2_q   <= pri2_d;
      pir2_q   <= pir2_d;
      sq02_q   <= sq02_d;
      sq12_q   <= sq12_d;
      as2_re_q <= as2_re_d;
      as2_im_q <= as2_im_d;
      as2_st_q <= as2_st_d;
    end
  end

  // Stage 3: cross sums and the divisor (or the magnitude's radicand).
  logic               v3_q;
  logic [2:0]         cmd3_q;
  logic signed [65:0] sum_re3_d, sum_im3_d, sum_re3_q, sum_im3_q;
  logic [63:0]        den3_q;
  logic [31:0]        as3_re_q, as3_im_q;
  cau_pkg::status_e   as3_st_q;

  always_comb begin
    if (cmd2_q == cau_pkg::CMD_MUL) begin
      sum_re3_d = 66'(prr2_q) - 66'(pii2_q);
      sum_im3_d = 66'(pri2_q) + 66'(pir2_q);
    end else begin
      sum_re3_d = 66'(prr2_q) + 66'(pii2_q);
      sum_im3_d = 66'(pir2_q) - 66'(pri2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      cmd3_q    <= cmd2_q;
      sum_re3_q <= sum_re3_d;
      sum_im3_q <= sum_im3_d;
      den3_q    <= unsigned'(sq02_q) + unsigned'(sq12_q);
      as3_re_q  <= as2_re_q;
      as3_im_q  <= as2_im_q;
      as3_st_q  <= as2_st_q;
    end
  end

  // Stage 4: sign and magnitude.
  logic             v4_q;
  logic [2:0]       cmd4_q;
  logic [63:0]      mag_re4_q, mag_im4_q, den4_q;
  logic             neg_re4_q, neg_im4_q;
  logic [31:0]      as4_re_q, as4_im_q;
  cau_pkg::status_e as4_st_q;

  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      cmd4_q    <= cmd3_q;
      neg_re4_q <= sum_re3_q[65];
      neg_im4_q <= sum_im3_q[65];
      mag_re4_q <= sum_re3_q[65] ? 64'(-sum_re3_q) : sum_re3_q[63:0];
      mag_im4_q <= sum_im3_q[65] ? 64'(-sum_im3_q) : sum_im3_q[63:0];
      den4_q    <= den3_q;
      as4_re_q  <= as3_re_q;
      as4_im_q  <= as3_im_q;
      as4_st_q  <= as3_st_q;
    end
  end

  // Stage 5: multiply result rounded and saturated; divider and root setup.
  logic           v5_q;
  cau_pkg::iter_t it5_d, it5_q;
  logic [64:0]    rnd_re, rnd_im;
  logic           msat_re, msat_im;
  logic [31:0]    mres_re, mres_im;

  always_comb begin
    rnd_re  = ({1'b0, mag_re4_q} + {1'b0, HALF}) >> FRAC_BITS;
    rnd_im  = ({1'b0, mag_im4_q} + {1'b0, HALF}) >> FRAC_BITS;
    msat_re = neg_re4_q ? (mag_re4_q >= NEG_LIM) : (mag_re4_q >= POS_LIM);
    msat_im = neg_im4_q ? (mag_im4_q >= NEG_LIM) : (mag_im4_q >= POS_LIM);
    if (msat_re) begin
      mres_re = neg_re4_q ? MAX_NEG : MAX_POS;
    end else begin
      mres_re = neg_re4_q ? (32'd0 - rnd_re[31:0]) : rnd_re[31:0];
    end
    if (msat_im) begin
      mres_im = neg_im4_q ? MAX_NEG : MAX_POS;
    end else begin
      mres_im = neg_im4_q ? (32'd0 - rnd_im[31:0]) : rnd_im[31:0];
    end

    it5_d.cmd           = cmd4_q;
    it5_d.den           = den4_q;
    it5_d.side.neg_re   = neg_re4_q;
    it5_d.side.neg_im   = neg_im4_q;
    it5_d.side.ovf_re   = ((mag_re4_q >> K) >= den4_q);
    it5_d.side.ovf_im   = ((mag_im4_q >> K) >= den4_q);
    it5_d.side.div_zero = (den4_q == 64'd0);
    if (cmd4_q == cau_pkg::CMD_MUL) begin
      it5_d.side.res_re = mres_re;
      it5_d.side.res_im = mres_im;
      it5_d.side.st     = (msat_re || msat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end else begin
      it5_d.side.res_re = as4_re_q;
      it5_d.side.res_im = as4_im_q;
      it5_d.side.st     = as4_st_q;
    end

    // The dividend's upper part becomes the first remainder; its low K bits,
    // followed by FRAC_BITS+1 zeros, give 33 quotient bits.
    it5_d.im.rem  = {1'b0, mag_im4_q >> K};
    it5_d.im.quo  = '0;
    it5_d.im.feed = {2'b00, mag_im4_q} << (66 - K);
    it5_d.re.quo  = '0;
    if (cmd4_q == cau_pkg::CMD_MAG) begin
      it5_d.re.rem  = '0;
      it5_d.re.feed = {2'b00, den4_q};
    end else begin
      it5_d.re.rem  = {1'b0, mag_re4_q >> K};
      it5_d.re.feed = {2'b00, mag_re4_q} << (66 - K);
    end
  end

  always_ff @(posedge clk_i) begin
    if (v4_q) begin
      it5_q <= it5_d;
    end
  end

  // Iteration stages.
  logic           v_it [0:cau_pkg::NSTEP];
  cau_pkg::iter_t d_it [0:cau_pkg::NSTEP];

  assign v_it[0] = v5_q;
  assign d_it[0] = it5_q;

  for (genvar g = 0; g < cau_pkg::NSTEP; g++) begin : g_iter
    cau_iter_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v_it[g]),
      .data_i  (d_it[g]),
      .valid_o (v_it[g+1]),
      .data_o  (d_it[g+1])
    );
  end

  // Stage F1: rounding of quotients, rounding of the root.
  logic           v6_q;
  logic [2:0]     cmd6_q;
  cau_pkg::side_t side6_q;
  logic [32:0]    val_re6_d, val_im6_d, val_re6_q, val_im6_q;
  cau_pkg::iter_t last;

  always_comb begin
    last      = d_it[cau_pkg::NSTEP];
    val_im6_d = 33'((34'(last.im.quo) + 34'd1) >> 1);
    if (last.cmd == cau_pkg::CMD_MAG) begin
      val_re6_d = last.re.quo + 33'(last.re.rem > {32'd0, last.re.quo});
    end else begin
      val_re6_d = 33'((34'(last.re.quo) + 34'd1) >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_it[cau_pkg::NSTEP]) begin
      cmd6_q    <= last.cmd;
      side6_q   <= last.side;
      val_re6_q <= val_re6_d;
      val_im6_q <= val_im6_d;
    end
  end

  // Stage F2: saturation and result selection.
  logic [32:0]      sat_re, sat_im;
  logic [31:0]      res_re_d, res_im_d, res_re_q, res_im_q;
  cau_pkg::status_e st_d, st_q;
  logic             done_q;

  // Returns {saturated, value}.
  function automatic logic [32:0] clamp(logic neg, logic [32:0] v, logic ovf);
    logic sat;
    if (neg) begin
      sat = ovf || (v > 33'h0_8000_0000);
    end else begin
      sat = ovf || (v > 33'h0_7FFF_FFFF);
    end
    if (sat) begin
      return {1'b1, neg ? MAX_NEG : MAX_POS};
    end
    return {1'b0, neg ? (32'd0 - v[31:0]) : v[31:0]};
  endfunction

  always_comb begin
    sat_re = clamp(side6_q.neg_re && (cmd6_q == cau_pkg::CMD_DIV), val_re6_q,
                   side6_q.ovf_re && (cmd6_q == cau_pkg::CMD_DIV));
    sat_im = clamp(side6_q.neg_im, val_im6_q, side6_q.ovf_im);
    res_re_d = '0;
    res_im_d = '0;
    st_d     = cau_pkg::ST_OK;
    case (cmd6_q) inside
      cau_pkg::CMD_ADD, cau_pkg::CMD_SUB, cau_pkg::CMD_MUL: begin
        res_re_d = side6_q.res_re;
        res_im_d = side6_q.res_im;
        st_d     = side6_q.st;
      end
      cau_pkg::CMD_DIV: begin
        if (side6_q.div_zero) begin
          st_d = cau_pkg::ST_DIV_ZERO;
        end else begin
          res_re_d = sat_re[31:0];
          res_im_d = sat_im[31:0];
          st_d     = (sat_re[32] || sat_im[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
      end
      cau_pkg::CMD_MAG: begin
        res_re_d = sat_re[31:0];
        st_d     = sat_re[32] ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      default: begin
        st_d = cau_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (v6_q) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      st_q     <= st_d;
    end
  end

  // Valid bits of the setup and output stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i && !busy_o;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      v6_q   <= v_it[cau_pkg::NSTEP];
      done_q <= v6_q;
    end
  end

  assign busy_o   = 1'b0;
  assign done_o   = done_q;
  assign res_re_o = res_re_q;
  assign res_im_o = res_im_q;
  assign status_o = st_q;

endmodule

>>> hw/rtl/cau_checker.sv
// Port-level checker for the complex arithmetic unit, bound to its top level.
// Depends on cau_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cau_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [2:0]  command_i,
  input logic [31:0] b_re_i,
  input logic [31:0] b_im_i,
  input logic [31:0] res_re_o,
  input logic [31:0] res_im_o,
  input logic [1:0]  status_o,
  input logic        done_o
);

  logic accept;
  logic div_zero_cmd;
  logic mag_cmd;
  logic div_zero_res;

  assign accept       = start_i && !busy_o;
  assign div_zero_cmd = accept && command_i == cau_pkg::CMD_DIV &&
                        b_re_i == 32'd0 && b_im_i == 32'd0;
  assign mag_cmd      = accept && command_i == cau_pkg::CMD_MAG;
  assign div_zero_res = done_o && status_o == cau_pkg::ST_DIV_ZERO;

  `CAU_ASSERT(a_result_follows, accept |-> ##(cau_pkg::LATENCY) done_o, "missing result")
  `CAU_ASSERT(a_no_spurious, done_o |-> $past(accept, cau_pkg::LATENCY), "result without transfer")
  `CAU_ASSERT(a_div_zero_src, div_zero_res |-> $past(div_zero_cmd, cau_pkg::LATENCY), "bad status")
  `CAU_ASSERT_NEVER(a_div_zero_res, div_zero_res && (res_re_o | res_im_o) != 32'd0, "nonzero")
  `CAU_ASSERT(a_mag_shape, (done_o && $past(mag_cmd, cau_pkg::LATENCY)) |-> mag_ok, "bad mag")

  logic mag_ok;
  assign mag_ok = (res_im_o == 32'd0) && !res_re_o[31];

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_o    (busy_o),
  .command_i (command_i),
  .b_re_i    (b_re_i),
  .b_im_i    (b_im_i),
  .res_re_o  (res_re_o),
  .res_im_o  (res_im_o),
  .status_o  (status_o),
  .done_o    (done_o)
);

>>> test/tb_complex_arith_unit.sv
// Self-checking testbench for complex_arith_unit: directed table, then random commands.
// Expected results come from the directed table or from a fixed-point model kept in this file.
// Depends on cau_pkg and the complex_arith_unit RTL.
module tb_complex_arith_unit;

  localparam int unsigned FRAC = 16;
  localparam logic [2:0] CMD_RSV5 = 3'd5;
  localparam logic [2:0] CMD_RSV6 = 3'd6;
  localparam logic [2:0] CMD_RSV7 = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_PER_PHASE = 350;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  st;
  } cplx_res_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] ar, ai, br, bi;
    bit          typed;
    cplx_res_t   res;
  } stim_row_t;

  logic        clk_i, rst_ni, start_i;
  logic [2:0]  command_i;
  logic [31:0] a_re_i, a_im_i, b_re_i, b_im_i;
  logic        busy_o, done_o;
  logic [31:0] res_re_o, res_im_o;
  logic [1:0]  status_o;

  cplx_res_t pending_results[$];
  int unsigned n_errors = 0;
  int unsigned n_checked = 0;
  int unsigned n_issued = 0;
  int unsigned cycle_cnt = 0;
  int unsigned idle_pct = 0;

  complex_arith_unit #(.FRAC_BITS(FRAC)) dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .command_i, .a_re_i, .a_im_i, .b_re_i, .b_im_i,
    .res_re_o, .res_im_o, .status_o, .done_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Wrapped 64-bit sum whose true value lies in (-2^63, 2^63] to sign and magnitude.
  function automatic bit [63:0] split_sign(bit [63:0] u, output bit neg);
    neg = u[63] && (u != 64'h8000_0000_0000_0000);
    return neg ? -u : u;
  endfunction

  function automatic logic [31:0] clamp32(bit neg, bit [63:0] m, inout bit sat);
    bit [63:0] t;
    if (neg) begin
      if (m > 64'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      t = -m;
      return t[31:0];
    end
    if (m > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return m[31:0];
  endfunction

  function automatic bit [63:0] round_frac(bit [63:0] m);
    return (m + (64'd1 << (FRAC - 1))) >> FRAC;
  endfunction

  function automatic bit [63:0] div_frac(bit [63:0] m, bit [63:0] den);
    bit [63:0] q, r;
    q = m / den;
    r = m % den;
    if (q >= (64'd1 << (32 - FRAC))) return 64'd1 << 33;
    for (int i = 0; i <= FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return (q + 64'd1) >> 1;
  endfunction

  function automatic bit [63:0] sqrt_round(bit [63:0] s);
    bit [63:0] root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= root + b) begin
        s = s - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    if (s > root) root = root + 1;
    return root;
  endfunction

  function automatic cplx_res_t cplx_predict(logic [2:0] cmd, logic [31:0] ar, logic [31:0] ai,
                                             logic [31:0] br, logic [31:0] bi);
    bit [63:0] xar, xai, xbr, xbi, sr, si, mr, mi, den;
    bit nr, ni, sat;
    cplx_res_t r;
    xar = {{32{ar[31]}}, ar};
    xai = {{32{ai[31]}}, ai};
    xbr = {{32{br[31]}}, br};
    xbi = {{32{bi[31]}}, bi};
    sat = 1'b0;
    r = '0;
    case (cmd) inside
      cau_pkg::CMD_ADD, cau_pkg::CMD_SUB: begin
        sr = (cmd == cau_pkg::CMD_ADD) ? xar + xbr : xar - xbr;
        si = (cmd == cau_pkg::CMD_ADD) ? xai + xbi : xai - xbi;
        r.re = clamp32(sr[63], sr[63] ? -sr : sr, sat);
        r.im = clamp32(si[63], si[63] ? -si : si, sat);
      end
      cau_pkg::CMD_MUL: begin
        mr = split_sign(xar * xbr - xai * xbi, nr);
        mi = split_sign(xar * xbi + xai * xbr, ni);
        r.re = clamp32(nr, round_frac(mr), sat);
        r.im = clamp32(ni, round_frac(mi), sat);
      end
      cau_pkg::CMD_DIV: begin
        den = xbr * xbr + xbi * xbi;
        if (den == 0) begin
          r.st = cau_pkg::ST_DIV_ZERO;
        end else begin
          mr = split_sign(xar * xbr + xai * xbi, nr);
          mi = split_sign(xai * xbr - xar * xbi, ni);
          r.re = clamp32(nr, div_frac(mr, den), sat);
          r.im = clamp32(ni, div_frac(mi, den), sat);
        end
      end
      cau_pkg::CMD_MAG: r.re = clamp32(1'b0, sqrt_round(xar * xar + xai * xai), sat);
      default: ;
    endcase
    if (sat) r.st = cau_pkg::ST_SAT;
    return r;
  endfunction

  // Issues one command and waits for its transfer; start_i stays high unless idling follows.
  task automatic issue_cmd(logic [2:0] cmd, logic [31:0] ar, logic [31:0] ai,
                           logic [31:0] br, logic [31:0] bi, bit typed, cplx_res_t res);
    start_i   <= 1'b1;
    command_i <= cmd;
    a_re_i    <= ar;
    a_im_i    <= ai;
    b_re_i    <= br;
    b_im_i    <= bi;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(typed ? res : cplx_predict(cmd, ar, ai, br, bi));
    n_issued++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk_i);
      @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_operand();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      3: v = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      4: v = $signed($urandom) >>> $urandom_range(0, 31);
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h0000_0001;
          default: v = 32'h0;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cplx_res_t e;
    if (done_o) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no expected result: re=%h im=%h st=%0d",
               res_re_o, res_im_o, status_o);
        n_errors++;
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (res_re_o !== e.re) begin
          $error("res_re: expected %h, got %h", e.re, res_re_o);
          n_errors++;
        end
        if (res_im_o !== e.im) begin
          $error("res_im: expected %h, got %h", e.im, res_im_o);
          n_errors++;
        end
        if (status_o !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, status_o);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_tbl[$];
    int unsigned idle_phases[4];
    logic [2:0] cmd;
    logic [31:0] br, bi;
    cplx_res_t none;
    none = '0;
    idle_phases = '{0, 49, 23, 0};
    dir_tbl = '{
      '{cau_pkg::CMD_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, cau_pkg::ST_OK}},
      '{cau_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'h0, 1,
        '{32'h7FFF_FFFF, 32'h0, cau_pkg::ST_SAT}},
      '{cau_pkg::CMD_ADD, 32'h0, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 1,
        '{32'h0, 32'h8000_0000, cau_pkg::ST_SAT}},
      '{cau_pkg::CMD_SUB, 32'h8000_0000, 32'h0, 32'h1, 32'h0, 1,
        '{32'h8000_0000, 32'h0, cau_pkg::ST_SAT}},
      '{cau_pkg::CMD_SUB, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 0, none},
      '{cau_pkg::CMD_MUL, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 1,
        '{32'h0001_0000, 32'h0, cau_pkg::ST_OK}},
      '{cau_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
        none},
      '{cau_pkg::CMD_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
        none},
      '{cau_pkg::CMD_MUL, 32'h0000_8000, 32'h0000_0001, 32'hFFFF_8000, 32'h0000_0003, 0,
        none},
      '{cau_pkg::CMD_DIV, 32'h1234_5678, 32'h8765_4321, 32'h0, 32'h0, 1,
        '{32'h0, 32'h0, cau_pkg::ST_DIV_ZERO}},
      '{cau_pkg::CMD_DIV, 32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0, 1,
        '{32'h0000_8000, 32'h0, cau_pkg::ST_OK}},
      '{cau_pkg::CMD_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h1, 0, none},
      '{cau_pkg::CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
        none},
      '{cau_pkg::CMD_DIV, 32'h0003_0000, 32'hFFFE_0000, 32'h0000_0007, 32'hFFFF_FFF0, 0,
        none},
      '{cau_pkg::CMD_MAG, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_FFFF, 32'h1, 1,
        '{32'h0005_0000, 32'h0, cau_pkg::ST_OK}},
      '{cau_pkg::CMD_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 0, none},
      '{cau_pkg::CMD_MAG, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 0, none},
      '{cau_pkg::CMD_MAG, 32'h0000_0001, 32'h0000_0001, 32'h0, 32'h0, 0, none},
      '{CMD_RSV5, 32'h1, 32'h2, 32'h3, 32'h4, 1, '{32'h0, 32'h0, cau_pkg::ST_OK}},
      '{CMD_RSV6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
        '{32'h0, 32'h0, cau_pkg::ST_OK}},
      '{CMD_RSV7, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1,
        '{32'h0, 32'h0, cau_pkg::ST_OK}}
    };

    rst_ni    = 1'b0;
    start_i   = 1'b0;
    command_i = cau_pkg::CMD_ADD;
    a_re_i    = '0;
    a_im_i    = '0;
    b_re_i    = '0;
    b_im_i    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i])
      issue_cmd(dir_tbl[i].cmd, dir_tbl[i].ar, dir_tbl[i].ai, dir_tbl[i].br, dir_tbl[i].bi,
                dir_tbl[i].typed, dir_tbl[i].res);

    foreach (idle_phases[p]) begin
      idle_pct = idle_phases[p];
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        br = rand_operand();
        bi = rand_operand();
        if (cmd == cau_pkg::CMD_DIV && $urandom_range(0, 9) == 0) begin
          br = '0;
          bi = '0;
        end
        issue_cmd(cmd, rand_operand(), rand_operand(), br, bi, 1'b0, none);
      end
      // Hold off between phases until the pipe has delivered everything.
      start_i <= 1'b0;
      wait_drained();
    end

    repeat (cau_pkg::LATENCY + 10) @(posedge clk_i);
    $display("Issued %0d commands (directed table and four idling phases), checked %0d results.",
             n_issued, n_checked);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, pending_results.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
